FILE: rtl/pump_schedule_override_controller_top_defines.svh
// Assertion macros shared by the checker of the pump schedule controller.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef PUMP_SCHEDULE_OVERRIDE_CONTROLLER_TOP_DEFINES_SVH
`define PUMP_SCHEDULE_OVERRIDE_CONTROLLER_TOP_DEFINES_SVH

// Checked only outside reset.
`define PSOC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define PSOC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: rtl/psoc_pkg.sv
// Shared types and constants of the pump schedule override controller.
// No dependencies; every other file but the defines header imports it.
package psoc_pkg;

    localparam int SEC_PER_DAY = 86400;
    localparam int SEC_PER_MIN = 60;
    localparam logic [31:0] MANUAL_TIMEOUT_MS = 32'd1800000;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCHED_EN   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCHED_MODE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WDAY_MASK  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MIN  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MIN    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 4'd7;

    // Remainder unit: 17-bit day count by an 8-bit period.
    localparam int MOD_DVD_W = 17;
    localparam int MOD_DIV_W = 8;
    localparam int MOD_CNT_W = $clog2(MOD_DVD_W);

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_FORCE_ON  = 3'd1,
        OP_FORCE_OFF = 3'd2,
        OP_RESET     = 3'd3,
        OP_SET_DIS   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        BTN_NONE  = 2'd0,
        BTN_SHORT = 2'd1,
        BTN_LONG  = 2'd2
    } t_btn;

    typedef enum logic [1:0] {
        OV_AUTO = 2'd0,
        OV_ON   = 2'd1,
        OV_OFF  = 2'd2
    } t_ovr;

    typedef enum logic [1:0] {
        MODE_WEEKDAY  = 2'd0,
        MODE_INTERVAL = 2'd1,
        MODE_DATE     = 2'd2,
        MODE_NEVER    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_PROD,
        ST_DAYS,
        ST_MOD,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic        sched_en;
        logic [1:0]  sched_mode;
        logic [6:0]  wday_mask;
        logic [10:0] start_min;
        logic [10:0] end_min;
        logic [7:0]  interval;
        logic [15:0] anchor;
        logic [15:0] target;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [MOD_DVD_W-1:0] dividend;
        logic [MOD_DIV_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } t_mod_status;

endpackage

FILE: rtl/psoc_if.sv
// Handshake interfaces of the pump schedule controller: item, result, config write.
// Depends on psoc_pkg.
interface psoc_in_if;
    import psoc_pkg::*;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [1:0]  button_event;
    logic [31:0] now_ms;
    logic [15:0] day_number;
    logic [16:0] second_of_day;
    logic [2:0]  day_of_week;

    modport source (output valid, operation, button_event, now_ms, day_number,
                    second_of_day, day_of_week, input ready);
    modport sink   (input valid, operation, button_event, now_ms, day_number,
                    second_of_day, day_of_week, output ready);
endinterface

interface psoc_out_if;
    logic       valid;
    logic       ready;
    logic       pump_on;
    logic [1:0] override_state;
    logic       schedule_active;

    modport source (output valid, pump_on, override_state, schedule_active, input ready);
    modport sink   (input valid, pump_on, override_state, schedule_active, output ready);
endinterface

interface psoc_cfg_if;
    import psoc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/psoc_cfg_regs.sv
// Configuration register file of the pump schedule controller.
// Depends on psoc_pkg and psoc_cfg_if.
module psoc_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    psoc_cfg_if.sink      i_cfg,
    output psoc_pkg::t_cfg o_cfg
);
    import psoc_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Everything clears except the interval period, which resets to one day.
            r_cfg <= '{interval: 8'd1, default: '0};
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SCHED_EN:   r_cfg.sched_en   <= i_cfg.data[0];
                CFG_SCHED_MODE: r_cfg.sched_mode <= i_cfg.data[1:0];
                CFG_WDAY_MASK:  r_cfg.wday_mask  <= i_cfg.data[6:0];
                CFG_START_MIN:  r_cfg.start_min  <= i_cfg.data[10:0];
                CFG_END_MIN:    r_cfg.end_min    <= i_cfg.data[10:0];
                CFG_INTERVAL:   r_cfg.interval   <= i_cfg.data[7:0];
                CFG_ANCHOR:     r_cfg.anchor     <= i_cfg.data;
                CFG_TARGET:     r_cfg.target     <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/psoc_mod_unit.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
// Depends on psoc_pkg.
module psoc_mod_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psoc_pkg::t_mod_req   i_req,
    output psoc_pkg::t_mod_status o_status
);
    import psoc_pkg::*;

    logic [MOD_DVD_W-1:0] r_dvd;
    logic [MOD_DIV_W-1:0] r_rem;
    logic [MOD_DIV_W-1:0] r_div;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [MOD_DIV_W:0]   shifted;
    logic [MOD_DIV_W+1:0] trial;

    // Bring down the next dividend bit and subtract the divisor if it fits.
    always_comb begin
        shifted = {r_rem, r_dvd[MOD_DVD_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= MOD_CNT_W'(MOD_DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[MOD_DVD_W-2:0], 1'b0};
            r_rem <= trial[MOD_DIV_W+1] ? shifted[MOD_DIV_W-1:0] : trial[MOD_DIV_W-1:0];
        end
    end

    assign o_status.busy     = r_busy;
    assign o_status.done     = r_done;
    assign o_status.rem_zero = (r_rem == '0);

endmodule

FILE: rtl/pump_schedule_override_controller_top.sv
// Top level of the pump schedule override controller: sequencer and override logic.
// Depends on psoc_pkg, psoc_if, psoc_cfg_regs and psoc_mod_unit.
//
//   channel   | dir | handshake           | transaction carries
//   ----------+-----+---------------------+----------------------------------------
//   i_item    | in  | valid/ready         | operation, button, time and date fields
//   o_result  | out | valid/ready         | pump_on, override_state, schedule_active
//   i_cfg     | in  | valid/ready (ready=1)| register index, write data
//
// Each item passes through the PREP, PROD, DAYS, MOD and APPLY steps before the next
// item is accepted; MOD runs the 17-step remainder of the interval day count.
// The block takes one item at a time, and it takes the next item while the
// previous result still waits in the output register.
// Reset (synchronous, active low) returns control and configuration to their
// reset values. A stalled result only holds the sequencer at its final step.
module pump_schedule_override_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psoc_in_if.sink     i_item,
    psoc_out_if.source  o_result,
    psoc_cfg_if.sink    i_cfg
);
    import psoc_pkg::*;

    // Configuration registers live in their own block.
    t_cfg        cfg;
    t_mod_req    mod_req;
    t_mod_status mod_status;

    psoc_cfg_regs u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (i_cfg),
        .o_cfg  (cfg)
    );

    psoc_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_status(mod_status)
    );

    t_state r_state, n_state;

    // Captured item.
    logic [2:0]  r_op;
    logic [1:0]  r_btn;
    logic [31:0] r_now;
    logic [15:0] r_day;
    logic [16:0] r_sec;
    logic [2:0]  r_dow;

    // Intermediate results of the schedule evaluation.
    logic signed [16:0] r_dd;       // day_number - anchor_day
    logic signed [17:0] r_rr;       // second_of_day - start_minute*60
    logic signed [34:0] r_prod;     // r_dd * seconds per day
    logic               r_win;
    logic               r_wk_hit;
    logic               r_date_hit;
    logic               r_timed_out;
    logic               r_int_ok;

    // Controller state.
    t_ovr        r_ovr, n_ovr;
    logic [31:0] r_start_ms, n_start_ms;
    logic        r_pump, n_pump;
    logic        r_dis, n_dis;

    // Output register.
    logic       r_out_valid;
    logic       r_out_pump;
    logic [1:0] r_out_ovr;
    logic       r_out_sched;

    logic accept;
    logic out_free;
    logic load_out;

    assign accept   = i_item.valid && i_item.ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign load_out = (r_state == ST_APPLY) && out_free;

    // Products and differences used by the window and interval tests.
    logic [16:0]        start_sec;
    logic [16:0]        end_sec;
    logic signed [34:0] diff;
    logic signed [17:0] adj;
    logic signed [17:0] days_s;
    logic [16:0]        days_c;
    logic               sched;

    localparam logic signed [17:0] DAY_S18  = 18'(SEC_PER_DAY);
    localparam logic signed [34:0] NEG_DAY  = -35'(SEC_PER_DAY);

    always_comb begin
        start_sec = 17'(cfg.start_min) * 17'(SEC_PER_MIN);
        end_sec   = 17'(cfg.end_min) * 17'(SEC_PER_MIN);

        // Elapsed seconds since the anchor start; truncation toward zero
        // lets anything less than a day before the start count as day 0.
        diff = r_prod + {{17{r_rr[17]}}, r_rr};
        if (r_rr < -DAY_S18) begin
            adj = -18'sd2;
        end else if (r_rr < 18'sd0) begin
            adj = -18'sd1;
        end else if (r_rr < DAY_S18) begin
            adj = 18'sd0;
        end else begin
            adj = 18'sd1;
        end
        days_s = {r_dd[16], r_dd} + adj;
        days_c = diff[34] ? 17'd0 : days_s[16:0];
    end

    always_comb begin
        sched = 1'b0;
        if (cfg.sched_en) begin
            case (t_mode'(cfg.sched_mode))
                MODE_WEEKDAY:  sched = r_wk_hit && r_win;
                MODE_INTERVAL: sched = r_int_ok && (cfg.interval != '0) &&
                                       mod_status.rem_zero && r_win;
                MODE_DATE:     sched = r_date_hit && r_win;
                default:       sched = 1'b0;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        i_item.ready     = 1'b0;
        mod_req.start    = 1'b0;
        mod_req.dividend = days_c;
        mod_req.divisor  = cfg.interval;
        case (r_state)
            ST_IDLE: begin
                i_item.ready = 1'b1;
                if (i_item.valid) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: n_state = ST_PROD;
            ST_PROD: n_state = ST_DAYS;
            ST_DAYS: begin
                mod_req.start = 1'b1;
                n_state       = ST_MOD;
            end
            ST_MOD: begin
                if (mod_status.done) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Item capture and the datapath steps ahead of the remainder.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_item.operation;
            r_btn <= i_item.button_event;
            r_now <= i_item.now_ms;
            r_day <= i_item.day_number;
            r_sec <= i_item.second_of_day;
            r_dow <= i_item.day_of_week;
        end
        if (r_state == ST_PREP) begin
            r_dd        <= $signed({1'b0, r_day}) - $signed({1'b0, cfg.anchor});
            r_rr        <= $signed({1'b0, r_sec}) - $signed({1'b0, start_sec});
            r_win       <= (r_sec >= start_sec) && (r_sec < end_sec);
            r_wk_hit    <= (r_dow <= 3'd6) && cfg.wday_mask[r_dow];
            r_date_hit  <= (r_day == cfg.target);
            r_timed_out <= (r_now - r_start_ms) > MANUAL_TIMEOUT_MS;
        end
        if (r_state == ST_PROD) begin
            r_prod <= r_dd * DAY_S18;
        end
        if (r_state == ST_DAYS) begin
            r_int_ok <= (diff > NEG_DAY);
        end
    end

    // Override logic, applied once per item in its final step.
    always_comb begin
        logic timed;
        n_ovr      = r_ovr;
        n_start_ms = r_start_ms;
        n_pump     = r_pump;
        n_dis      = r_dis;
        timed      = r_timed_out;
        case (t_op'(r_op))
            OP_TICK: begin
                case (t_btn'(r_btn))
                    BTN_SHORT: begin
                        if (r_pump) begin
                            n_ovr = OV_OFF;
                        end else begin
                            n_ovr      = OV_ON;
                            n_start_ms = r_now;
                            timed      = 1'b0;
                        end
                    end
                    BTN_LONG: begin
                        n_ovr = OV_AUTO;
                        n_dis = 1'b0;
                    end
                    default: ;
                endcase
                // Manual on times out; manual off ends with the window.
                if (n_ovr == OV_ON && timed) begin
                    n_ovr = OV_AUTO;
                end
                if (n_ovr == OV_OFF && !sched) begin
                    n_ovr = OV_AUTO;
                end
                if (n_ovr == OV_ON) begin
                    n_pump = 1'b1;
                end else if (n_ovr == OV_OFF) begin
                    n_pump = 1'b0;
                end else begin
                    n_pump = !n_dis && sched;
                end
            end
            OP_FORCE_ON: begin
                n_ovr      = OV_ON;
                n_start_ms = r_now;
            end
            OP_FORCE_OFF: n_ovr = OV_OFF;
            OP_RESET:     n_ovr = OV_AUTO;
            OP_SET_DIS:   n_dis = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovr       <= OV_AUTO;
            r_start_ms  <= '0;
            r_pump      <= 1'b0;
            r_dis       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_ovr       <= n_ovr;
                r_start_ms  <= n_start_ms;
                r_pump      <= n_pump;
                r_dis       <= n_dis;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_pump  <= n_pump;
            r_out_ovr   <= n_ovr;
            r_out_sched <= sched;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.pump_on         = r_out_pump;
    assign o_result.override_state  = r_out_ovr;
    assign o_result.schedule_active = r_out_sched;

endmodule

FILE: rtl/psoc_checker.sv
// Port-level assertions for the pump schedule controller, bound to its top level.
// Depends on psoc_pkg and pump_schedule_override_controller_top_defines.svh.
`include "pump_schedule_override_controller_top_defines.svh"

module psoc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_pump_on,
    input logic [1:0] i_override_state,
    input logic       i_schedule_active
);
    import psoc_pkg::*;

    logic in_acc;
    logic out_stall;

    assign in_acc    = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;

    // One item at a time: after a transaction the input closes.
    `PSOC_ASSERT(a_one_item, in_acc |=> !i_in_ready, "input ready after an accepted item")

    // A result cannot appear in the cycle right after an item is taken.
    `PSOC_ASSERT(a_min_latency, in_acc |=> !$rose(i_out_valid), "result too early")

    // A stalled result keeps its fields.
    `PSOC_ASSERT(a_out_hold, out_stall |=> i_out_valid && $stable(i_pump_on) && $stable(i_override_state) && $stable(i_schedule_active), "stalled result changed")

    // Override state code three is never produced.
    `PSOC_ASSERT(a_ovr_code, i_out_valid |-> (i_override_state != 2'd3), "bad override state")

    // Reset empties the output register.
    `PSOC_ASSERT_ALWAYS(a_reset_out, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind pump_schedule_override_controller_top psoc_checker u_psoc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_item.valid),
    .i_in_ready       (i_item.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_pump_on        (o_result.pump_on),
    .i_override_state (o_result.override_state),
    .i_schedule_active(o_result.schedule_active)
);
